>>> design/cfa_pkg.sv
// cfa_pkg: shared types and constants of the contiguous frame allocator
// used by every design module but cfa_checker; no dependencies

package cfa_pkg;

  localparam int MAX_FRAMES_DEF = 1024;

  localparam logic [1:0] FS_FREE  = 2'd0;
  localparam logic [1:0] FS_HEAD  = 2'd1;
  localparam logic [1:0] FS_ALLOC = 2'd3;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_RUN = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_NOHEAD = 2'd3;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_MAP   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } cfa_state_t;

  // control shared by every cell of the ring
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> design/cfa_cell.sv
// cfa_cell: one frame state cell of the rotating ring
// depends on cfa_pkg

module cfa_cell
  import cfa_pkg::*;
#(
  parameter logic [1:0] RST_VAL = FS_FREE
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic [1:0] load_val,
  input  logic [1:0] shift_in,
  output logic [1:0] q
);

  logic [1:0] q_r;
  logic [1:0] q_nxt;

  // rebuild load wins over rotation
  always_comb begin
    q_nxt = q_r;
    if (ctl.load) begin
      q_nxt = load_val;
    end else if (ctl.shift) begin
      q_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= RST_VAL;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> design/contiguous_frame_allocator.sv
// Contiguous frame allocator: keeps a state per frame (free, head, allocated)
// in a ring of MAX_FRAMES cells that, while a request is processed, rotates one
// frame per cycle past a single update point, so every request that is not
// rejected at once walks the whole ring. A successful allocate makes a first-fit
// search pass and then a marking pass; an allocate whose search fails ends
// after the search pass. Release and reserve make only the write pass; rejected
// requests give their result on the cycle after acceptance. One request is in
// flight at a time and the result is held in the output register until taken;
// the next request is accepted once the result has gone. A configuration write
// rebuilds the map with a single load of every cell. Depends on cfa_pkg and
// cfa_cell.

module contiguous_frame_allocator
  import cfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // frame_number[19:0], frame_total[30:20], zero
  input  logic [1:0]  in_tuser,  // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // first_frame[19:0], free_left[30:20], zero
  output logic [1:0]  out_tuser, // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int IW = $clog2(MAX_FRAMES);
  localparam int NW = IW + 1;
  localparam int PW = (NW > 11) ? NW : 11;
  localparam int EW = PW + 2;
  localparam logic [IW-1:0] LAST_POS = IW'(MAX_FRAMES - 1);
  localparam logic [PW-1:0] MAX_P = PW'(MAX_FRAMES);
  localparam logic [PW-1:0] RST_POOL = (MAX_FRAMES < 1024) ? MAX_P : PW'(1024);

  // configuration registers
  logic [19:0] base_r;
  logic [10:0] count_r;
  logic        map_r;

  // control and working registers
  cfa_state_t  state_r, state_nxt;
  logic [IW-1:0] pos_r;
  logic [10:0] free_r, free_nxt;
  logic [10:0] run_r, run_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic        found_r, found_nxt;
  logic        rel_mode_r;
  logic        rel_on_r, rel_on_nxt;
  logic [1:0]  wstat_r, wstat_nxt;
  logic [IW-1:0] ms_r;
  logic [10:0] len_r;
  logic        out_valid_r;
  logic [19:0] out_first_r;
  logic [1:0]  out_stat_r;
  logic [10:0] out_free_r;

  logic [1:0] ring [MAX_FRAMES];
  logic [1:0] wval;
  cell_ctl_t  cctl;

  logic        idle;
  logic        in_acc, cfg_acc, out_acc;
  logic [1:0]  kind;
  logic [19:0] fnum;
  logic [10:0] flen;
  logic [PW-1:0] pool;
  logic [21:0] pool_end;
  logic        rel_ok, res_ok;
  logic [PW-1:0] pos_w;
  logic        in_pool, last_pos;
  logic [EW-1:0] mark_end;
  logic        mark_hit;
  logic        finish;
  logic [19:0] fin_first;
  logic [1:0]  fin_stat;
  logic [10:0] fin_free;
  logic [19:0] nb;
  logic [10:0] nc;
  logic        nm;
  logic [PW-1:0] npool;
  logic        rebuild_map;

  assign kind = in_tuser;
  assign fnum = in_tdata[19:0];
  assign flen = in_tdata[30:20];

  assign idle      = (state_r == ST_IDLE) && !out_valid_r;
  assign in_tready = idle;
  assign cfg_ready = idle;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_acc   = out_valid_r && out_tready;

  // pool size and range checks
  assign pool     = ({{(PW-11){1'b0}}, count_r} > MAX_P) ? MAX_P
                  : {{(PW-11){1'b0}}, count_r};
  assign pool_end = {2'b00, base_r} + 22'(pool);
  assign rel_ok   = (fnum >= base_r) && ({2'b00, fnum} < pool_end);
  assign res_ok   = (flen != 11'd0) && (fnum >= base_r)
                  && ({2'b00, fnum} + {11'd0, flen} <= pool_end);

  // frame at the update point
  assign pos_w    = {{(PW-IW){1'b0}}, pos_r};
  assign in_pool  = pos_w < pool;
  assign last_pos = pos_r == LAST_POS;
  assign mark_end = EW'(ms_r) + EW'(len_r);
  assign mark_hit = (pos_r >= ms_r) && (EW'(pos_r) < mark_end);

  // new configuration values for a rebuild
  assign nb = (cfg_index == REG_BASE)  ? cfg_data : base_r;
  assign nc = (cfg_index == REG_COUNT) ? cfg_data[10:0] : count_r;
  assign nm = (cfg_index == REG_MAP)   ? cfg_data[0] : map_r;
  assign npool = ({{(PW-11){1'b0}}, nc} > MAX_P) ? MAX_P : {{(PW-11){1'b0}}, nc};
  assign rebuild_map = nm && (npool != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_ALLOC && flen != 11'd0) begin
            state_nxt = ST_SCAN;
          end else if ((kind == KIND_RELEASE && rel_ok)
                       || (kind == KIND_RESERVE && res_ok)) begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_SCAN: begin
        if (last_pos) begin
          state_nxt = found_nxt ? ST_WRITE : ST_IDLE;
        end
      end
      ST_WRITE: begin
        if (last_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    cctl.shift = 1'b0;
    cctl.load  = cfg_acc && (cfg_index != 2'd3);
    wval       = ring[0];
    free_nxt   = free_r;
    run_nxt    = run_r;
    start_nxt  = start_r;
    found_nxt  = found_r;
    rel_on_nxt = rel_on_r;
    wstat_nxt  = wstat_r;
    finish     = 1'b0;
    fin_first  = 20'd0;
    fin_stat   = STAT_OK;
    fin_free   = free_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind == KIND_ALLOC) begin
            if (flen == 11'd0) begin
              finish   = 1'b1;
              fin_stat = STAT_NO_RUN;
            end
          end else if (kind == KIND_RELEASE) begin
            if (!rel_ok) begin
              finish   = 1'b1;
              fin_stat = STAT_RANGE;
            end
          end else if (kind == KIND_RESERVE) begin
            if (!res_ok) begin
              finish   = 1'b1;
              fin_stat = STAT_RANGE;
            end
          end else begin
            finish   = 1'b1;
            fin_stat = STAT_RANGE;
          end
        end
      end
      ST_SCAN: begin
        cctl.shift = 1'b1;
        if (in_pool && !found_r) begin
          if (ring[0] == FS_FREE) begin
            if (run_r == 11'd0) begin
              start_nxt = pos_r;
            end
            run_nxt = run_r + 11'd1;
            if (run_r + 11'd1 == len_r) begin
              found_nxt = 1'b1;
            end
          end else begin
            run_nxt = 11'd0;
          end
        end
        if (last_pos && !found_nxt) begin
          finish   = 1'b1;
          fin_stat = STAT_NO_RUN;
        end
      end
      ST_WRITE: begin
        cctl.shift = 1'b1;
        if (rel_mode_r) begin
          if (pos_r == ms_r) begin
            if (ring[0] == FS_HEAD) begin
              wval       = FS_FREE;
              free_nxt   = free_r + 11'd1;
              rel_on_nxt = 1'b1;
            end else begin
              wstat_nxt = STAT_NOHEAD;
            end
          end else if (pos_r > ms_r) begin
            if (rel_on_r && in_pool && ring[0] == FS_ALLOC) begin
              wval     = FS_FREE;
              free_nxt = free_r + 11'd1;
            end else begin
              rel_on_nxt = 1'b0;
            end
          end
        end else if (mark_hit) begin
          wval = (pos_r == ms_r) ? FS_HEAD : FS_ALLOC;
          if (ring[0] == FS_FREE && free_r != 11'd0) begin
            free_nxt = free_r - 11'd1;
          end
        end
        if (last_pos) begin
          finish    = 1'b1;
          fin_stat  = wstat_nxt;
          fin_free  = free_nxt;
          fin_first = (!rel_mode_r && found_r) ? base_r + 20'(ms_r) : 20'd0;
        end
      end
      default: ;
    endcase
  end

  // ring of frame cells, rotating towards index 0
  for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_cell
    logic [1:0] sin;
    logic [1:0] lval;
    if (j == MAX_FRAMES - 1) begin : g_tail
      assign sin = wval;
    end else begin : g_link
      assign sin = ring[j+1];
    end
    if (j == 0) begin : g_first
      assign lval = rebuild_map ? FS_HEAD : FS_FREE;
    end else begin : g_rest
      assign lval = FS_FREE;
    end
    cfa_cell #(
      .RST_VAL ((j == 0) ? FS_HEAD : FS_FREE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cctl),
      .load_val (lval),
      .shift_in (sin),
      .q        (ring[j])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= 20'd0;
      count_r     <= 11'd1024;
      map_r       <= 1'b1;
      free_r      <= 11'(RST_POOL - PW'(1));
      found_r     <= 1'b0;
      rel_on_r    <= 1'b0;
      run_r       <= 11'd0;
      wstat_r     <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      if (cctl.shift) begin
        pos_r <= last_pos ? '0 : pos_r + IW'(1);
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (cctl.load) begin
        base_r  <= nb;
        count_r <= nc;
        map_r   <= nm;
        free_r  <= 11'(npool) - {10'd0, rebuild_map};
      end else begin
        free_r <= free_nxt;
      end
      if (in_acc) begin
        found_r  <= 1'b0;
        rel_on_r <= 1'b0;
        run_r    <= 11'd0;
        wstat_r  <= STAT_OK;
      end else begin
        found_r  <= found_nxt;
        rel_on_r <= rel_on_nxt;
        run_r    <= run_nxt;
        wstat_r  <= wstat_nxt;
      end
    end
  end

  // request payload and result registers
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    if (in_acc) begin
      len_r      <= flen;
      rel_mode_r <= (kind == KIND_RELEASE);
      ms_r       <= IW'(fnum - base_r);
    end else if (state_r == ST_SCAN && last_pos) begin
      ms_r <= start_nxt;
    end
    if (finish) begin
      out_first_r <= fin_first;
      out_stat_r  <= fin_stat;
      out_free_r  <= fin_free;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_first_r};
  assign out_tuser  = out_stat_r;

endmodule

>>> design/cfa_checker.sv
// cfa_checker: port-level assertions for the contiguous frame allocator
// bound to contiguous_frame_allocator; no package dependency

module cfa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request in flight: no second transaction straight after one
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while busy");

  // failed requests report first frame zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'd0 |-> out_tdata[19:0] == 20'd0)
    else $error("nonzero first frame on failure");

  // configuration never overlaps a pending result
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !out_tvalid && in_tready)
    else $error("configuration taken while busy");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

>>> bench/tb_top.sv
// tb_top: self-checking bench for the contiguous frame allocator
// drives requests and register writes, predicts each result with a frame-map model
// depends on cfa_pkg and contiguous_frame_allocator
`timescale 1ns / 100ps

module tb_top;
  import cfa_pkg::*;

  localparam int NFR        = MAX_FRAMES_DEF;
  localparam int WATCH_MAX  = 40000;
  localparam int N_RANDOM   = 270;

  typedef struct packed {
    logic [19:0] first_frame;
    logic [1:0]  status;
    logic [10:0] free_left;
  } alloc_result_t;

  // frame-map model and queue of expected results
  class alloc_scoreboard;
    logic [1:0]    fmap [NFR];
    logic [19:0]   base;
    logic [10:0]   count;
    logic          map_res;
    int            free_cnt;
    alloc_result_t pending [$];
    int            n_bad;
    int            n_ok;
    int            n_kind [4];

    function new();
      base = 0;
      count = 11'd1024;
      map_res = 1'b1;
      n_bad = 0;
      n_ok = 0;
      rebuild();
    endfunction

    function int pool_frames();
      return (int'(count) < NFR) ? int'(count) : NFR;
    endfunction

    function void rebuild();
      int n;
      n = pool_frames();
      foreach (fmap[i]) fmap[i] = FS_FREE;
      free_cnt = n;
      if (map_res && n > 0) begin
        fmap[0] = FS_HEAD;
        free_cnt = n - 1;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        REG_BASE:  base = val;
        REG_COUNT: count = val[10:0];
        REG_MAP:   map_res = val[0];
        default:   return;
      endcase
      rebuild();
    endfunction

    function void mark(int start, int len);
      for (int i = 0; i < len; i++) begin
        if (start + i < NFR) begin
          if (fmap[start + i] == FS_FREE && free_cnt > 0) free_cnt--;
          fmap[start + i] = (i == 0) ? FS_HEAD : FS_ALLOC;
        end
      end
    endfunction

    // note an accepted request and queue its expected result
    function void note_request(logic [1:0] kind, logic [19:0] fnum, logic [10:0] len);
      int n, run, start, k;
      bit found;
      alloc_result_t r;
      n = pool_frames();
      r = '0;
      run = 0;
      start = 0;
      found = 0;
      n_kind[kind]++;
      if (kind == KIND_ALLOC) begin
        if (len != 0) begin
          for (int i = 0; i < n; i++) begin
            if (fmap[i] == FS_FREE) begin
              if (run == 0) start = i;
              run++;
              if (run == int'(len)) begin
                found = 1;
                break;
              end
            end else run = 0;
          end
        end
        if (found) begin
          mark(start, len);
          r.first_frame = base + 20'(start);
          r.status = STAT_OK;
        end else r.status = STAT_NO_RUN;
      end else if (kind == KIND_RELEASE) begin
        if (int'(fnum) < int'(base) || int'(fnum) >= int'(base) + n) r.status = STAT_RANGE;
        else begin
          k = int'(fnum) - int'(base);
          if (fmap[k] != FS_HEAD) r.status = STAT_NOHEAD;
          else begin
            fmap[k] = FS_FREE;
            free_cnt++;
            for (k = k + 1; k < n; k++) begin
              if (fmap[k] != FS_ALLOC) break;
              fmap[k] = FS_FREE;
              free_cnt++;
            end
            r.status = STAT_OK;
          end
        end
      end else if (kind == KIND_RESERVE) begin
        if (len == 0 || int'(fnum) < int'(base) ||
            int'(fnum) + int'(len) > int'(base) + n) r.status = STAT_RANGE;
        else begin
          mark(int'(fnum) - int'(base), len);
          r.status = STAT_OK;
        end
      end else r.status = STAT_RANGE;
      r.free_left = 11'(free_cnt);
      pending.push_back(r);
    endfunction

    // compare one result against the oldest expectation
    function void check_result(logic [19:0] ff, logic [1:0] st, logic [10:0] fl);
      alloc_result_t e;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result ff=%0d st=%0d free=%0d", ff, st, fl);
        return;
      end
      e = pending.pop_front();
      if (e.first_frame !== ff || e.status !== st || e.free_left !== fl) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: exp ff=%0d st=%0d free=%0d, got ff=%0d st=%0d free=%0d",
                   e.first_frame, e.status, e.free_left, ff, st, fl);
      end else n_ok++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  alloc_scoreboard sb;
  bit calm;
  int idle_cycles;
  int sent;

  always #5 clk = ~clk;

  contiguous_frame_allocator dut (.*);

  // result side: random stalls, checks on each transaction
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[19:0], out_tuser, out_tdata[30:20]);
      if (!rst_n || calm || $urandom_range(3) != 0) out_tready <= rst_n;
      else begin
        gap = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_MAX) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] kind, logic [19:0] fnum, logic [10:0] len);
    @(posedge clk);
    if (!calm && $urandom_range(3) == 0) repeat ($urandom_range(1, 8)) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {1'b0, len, fnum};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, fnum, len);
    sent++;
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // random frame, mostly inside or near the pool
  function automatic logic [19:0] pick_frame();
    int n;
    n = sb.pool_frames();
    case ($urandom_range(9))
      0: return 20'($urandom);
      1: return sb.base - 20'd1;
      default: return sb.base + 20'($urandom_range(0, n));
    endcase
  endfunction

  task automatic random_phase(int cnt);
    logic [1:0] k;
    logic [10:0] len;
    for (int i = 0; i < cnt; i++) begin
      k = 2'($urandom_range(0, 9) < 4 ? KIND_ALLOC : ($urandom_range(0, 5) < 3 ?
            KIND_RELEASE : ($urandom_range(0, 9) == 0 ? 2'd3 : KIND_RESERVE)));
      len = ($urandom_range(0, 15) == 0) ? 11'($urandom) : 11'($urandom_range(0, 24));
      send_req(k, pick_frame(), len);
    end
  endtask

  initial begin
    sb = new();
    calm = 0;
    sent = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default pool with the map frame reserved
    send_req(KIND_ALLOC, 20'd0, 11'd0);
    send_req(KIND_ALLOC, 20'hFFFFF, 11'd1);
    send_req(KIND_ALLOC, 20'd0, 11'd5);
    send_req(KIND_RELEASE, 20'd3, 11'd0);
    send_req(KIND_RELEASE, 20'd1, 11'h7FF);
    send_req(KIND_RESERVE, 20'd0, 11'd4);
    send_req(KIND_RESERVE, 20'd2, 11'd0);
    send_req(KIND_RESERVE, 20'd1020, 11'd5);
    send_req(KIND_RESERVE, 20'd1023, 11'd1);
    send_req(KIND_RELEASE, 20'd1023, 11'd0);
    send_req(KIND_RELEASE, 20'd1024, 11'd0);
    send_req(2'd3, 20'd5, 11'd5);
    send_req(KIND_ALLOC, 20'd0, 11'd1024);
    send_req(KIND_RELEASE, 20'd0, 11'd0);
    send_req(KIND_ALLOC, 20'd0, 11'd1024);
    send_req(KIND_ALLOC, 20'd0, 11'h7FF);

    // small pool at the top of the frame space
    write_cfg(REG_COUNT, 20'd8);
    write_cfg(REG_BASE, 20'hFFFFC);
    send_req(KIND_ALLOC, 20'd0, 11'd7);
    send_req(KIND_ALLOC, 20'd0, 11'd1);
    send_req(KIND_RELEASE, 20'hFFFFD, 11'd0);
    send_req(KIND_RESERVE, 20'hFFFFB, 11'd1);
    random_phase(50);

    write_cfg(REG_MAP, 20'd0);
    write_cfg(REG_BASE, 20'd0);
    random_phase(60);

    write_cfg(REG_COUNT, 20'd64);
    write_cfg(REG_BASE, 20'd300);
    random_phase(60);

    write_cfg(REG_MAP, 20'd1);
    write_cfg(REG_COUNT, 20'd1024);
    write_cfg(REG_BASE, 20'd512);
    random_phase(50);

    // last part without stalls
    calm = 1;
    write_cfg(REG_COUNT, 20'd16);
    random_phase(N_RANDOM - 220);

    drain();
    repeat (20) @(posedge clk);
    $display("%0d requests sent (alloc %0d, release %0d, reserve %0d, other %0d)",
             sent, sb.n_kind[0], sb.n_kind[1], sb.n_kind[2], sb.n_kind[3]);
    $display("%0d results matched over six pool settings, %0d mismatches",
             sb.n_ok, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
